// ===== rtl/sctm_pkg.sv =====
// ----------------------------------------------------------------------------
// sctm_pkg
// Shared types and constants of the shunt current trimmed-mean monitor.
// ----------------------------------------------------------------------------
package sctm_pkg;

   // control register indexes
   localparam logic [2:0] CSR_ZERO_OFFSET = 3'd0;
   localparam logic [2:0] CSR_INVERT_SIGN = 3'd1;
   localparam logic [2:0] CSR_GAIN_Q8     = 3'd2;
   localparam logic [2:0] CSR_IDLE_BAND   = 3'd3;
   localparam logic [2:0] CSR_FAULT_LIMIT = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // register reset values
   localparam logic [15:0] GAIN_Q8_RST     = 16'd3416;
   localparam logic [19:0] IDLE_BAND_RST   = 20'd500;
   localparam logic [15:0] FAULT_LIMIT_RST = 16'd5;

   localparam logic [15:0] FAIL_COUNT_MAX = 16'hFFFF;

   // quotient bits after the saturation check (result magnitude < 2^23)
   localparam int QUO_W = 23;
   localparam logic [QUO_W-1:0] CURRENT_MAX = 23'h7F_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_TRIM,
      ST_DIFF,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_FIN
   } sctm_state_type;

endpackage

// ===== rtl/shunt_current_trimmed_mean_monitor.sv =====
// ----------------------------------------------------------------------------
// shunt_current_trimmed_mean_monitor
// Bus-fault tracking, sample window, trimmed mean, offset, gain and idle band
// for one shunt current sensor, computed by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | bus_ok, shunt_code
//  rsp     | out       | rsp_valid/stall   | current_valid, current_ma,
//          |           |                   | sensor_fault, reinit_sensor
//  csr     | in        | csr_valid/ready   | csr_index, csr_wdata
//
//  A failed tick, or a good tick before the window is full, gives its word at
//  the accepting edge. A computing tick runs the sum/min/max walk (one
//  registered ring read per sample), then four datapath steps, one reciprocal
//  multiply for the divide by WINDOW_SIZE-2 and a step that loads the word
//  (the multiply step is skipped when the value is idle or saturates).
//  Reset clears control state only; the ring holds no reset value.
//  req_stall is high while computing and while a result word is stalled.
// ----------------------------------------------------------------------------
module shunt_current_trimmed_mean_monitor
   import sctm_pkg::*;
#(
   parameter int WINDOW_SIZE = 8
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_bus_ok,
   input  logic signed [15:0]     req_shunt_code,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_current_valid,
   output logic signed [23:0]     rsp_current_ma,
   output logic                   rsp_sensor_fault,
   output logic                   rsp_reinit_sensor,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int D        = WINDOW_SIZE - 2;
   localparam int DEN      = D * 256;
   localparam int SLOT_W   = $clog2(WINDOW_SIZE);
   localparam int CNT_W    = $clog2(WINDOW_SIZE + 1);
   localparam int SUM_W    = 16 + $clog2(WINDOW_SIZE);
   localparam int DIFF_W   = 18 + $clog2(WINDOW_SIZE);
   localparam int MAG_W    = DIFF_W - 1 + 16;
   localparam int Y_W      = MAG_W - 7;
   localparam longint SAT_LIM = 64'd8388608 * D;
   // unsaturated dividend is below D * 2^23; reciprocal exact over that range
   localparam int YQ_W     = QUO_W + $clog2(D);
   localparam int RECIP_K  = YQ_W + $clog2(D);
   localparam int RECIP_W  = YQ_W + 1;
   localparam int PROD_W   = YQ_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((64'd1 << RECIP_K) + D - 1) / D);

   // configuration
   logic signed [15:0] zero_offset_ff;
   logic               invert_sign_ff;
   logic [15:0]        gain_ff;
   logic [19:0]        idle_band_ff;
   logic [15:0]        fault_limit_ff;

   // tick state
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               full_ff, full_in;
   logic [15:0]        fail_ff, fail_in;
   logic               fault_ff, fault_in;
   logic               pend_reinit_ff, pend_reinit_in;

   // ring memory
   logic signed [15:0] ring [WINDOW_SIZE];
   logic               wr_en;
   logic               rd_en;
   logic signed [15:0] rd_data_ff;
   logic               rd_vld_ff;

   // sequencer and datapath
   sctm_state_type         state_ff, state_in;
   logic [CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0]       acc_cnt_ff, acc_cnt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [15:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic signed [SUM_W-1:0] trim_ff, trim_in;
   logic signed [DIFF_W-1:0] offd_ff;
   logic [MAG_W-1:0]       idle_lim_ff;
   logic [DIFF_W-2:0]      absd_ff, absd_in;
   logic                   neg_ff, neg_in;
   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic [YQ_W-1:0]        y_ff, y_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;

   // result word
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic signed [23:0]     cur_ma_ff, cur_ma_in;
   logic                   fault_o_ff, fault_o_in;
   logic                   reinit_o_ff, reinit_o_in;

   logic                   out_free;
   logic                   accept;
   logic [15:0]            fail_inc;
   logic                   limit_hit;
   logic [SLOT_W-1:0]      slot_next;
   logic                   full_next;
   logic signed [DIFF_W-1:0] d_pos, d_neg;
   logic [MAG_W:0]         y_sum;
   logic [Y_W-1:0]         y_val;
   logic [PROD_W-1:0]      recip_prod;
   logic [23:0]            quo_ext;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_valid = cur_valid_ff;
   assign rsp_current_ma    = cur_ma_ff;
   assign rsp_sensor_fault  = fault_o_ff;
   assign rsp_reinit_sensor = reinit_o_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= '0;
         invert_sign_ff <= 1'b0;
         gain_ff        <= GAIN_Q8_RST;
         idle_band_ff   <= IDLE_BAND_RST;
         fault_limit_ff <= FAULT_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_OFFSET: zero_offset_ff <= csr_wdata[15:0];
            CSR_INVERT_SIGN: invert_sign_ff <= csr_wdata[0];
            CSR_GAIN_Q8:     gain_ff        <= csr_wdata[15:0];
            CSR_IDLE_BAND:   idle_band_ff   <= csr_wdata;
            CSR_FAULT_LIMIT: fault_limit_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // config-derived thresholds; the user must change config only while idle (not enforced here)
   always_ff @(posedge clock) begin
      offd_ff     <= DIFF_W'(zero_offset_ff) * DIFF_W'(D);
      idle_lim_ff <= MAG_W'(idle_band_ff) * MAG_W'(DEN);
   end

   // ring: write on a good tick, one read per sample during the walk
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[slot_ff] <= req_shunt_code;
      end
      if (rd_en) begin
         rd_data_ff <= ring[rd_cnt_ff[SLOT_W-1:0]];
      end
   end

   assign fail_inc  = (fail_ff < FAIL_COUNT_MAX) ? fail_ff + 16'd1 : fail_ff;
   assign limit_hit = fail_inc >= fault_limit_ff;
   assign slot_next = (slot_ff == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_ff + 1'b1;
   assign full_next = full_ff || (slot_next == '0);

   assign d_pos      = DIFF_W'(trim_ff) - offd_ff;
   assign d_neg      = offd_ff - DIFF_W'(trim_ff);
   assign y_sum      = {1'b0, mag_ff} + (MAG_W + 1)'(DEN / 2);
   assign y_val      = y_sum[MAG_W:8];
   assign recip_prod = PROD_W'(y_ff) * PROD_W'(RECIP_M);
   assign quo_ext    = {1'b0, quo_ff};

   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      full_in        = full_ff;
      fail_in        = fail_ff;
      fault_in       = fault_ff;
      pend_reinit_in = pend_reinit_ff;
      rd_cnt_in      = rd_cnt_ff;
      acc_cnt_in     = acc_cnt_ff;
      sum_in         = sum_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      trim_in        = trim_ff;
      absd_in        = absd_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      y_in           = y_ff;
      quo_in         = quo_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cur_valid_in   = cur_valid_ff;
      cur_ma_in      = cur_ma_ff;
      fault_o_in     = fault_o_ff;
      reinit_o_in    = reinit_o_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_bus_ok) begin
                  fail_in = fail_inc;
                  if (limit_hit) begin
                     fault_in = 1'b1;
                     full_in  = 1'b0;
                     slot_in  = '0;
                  end
                  rsp_valid_in = 1'b1;
                  cur_valid_in = 1'b0;
                  cur_ma_in    = '0;
                  fault_o_in   = limit_hit ? 1'b1 : fault_ff;
                  reinit_o_in  = 1'b0;
               end else begin
                  fail_in  = '0;
                  fault_in = 1'b0;
                  wr_en    = 1'b1;
                  slot_in  = slot_next;
                  full_in  = full_next;
                  if (full_next) begin
                     pend_reinit_in = fail_ff >= fault_limit_ff;
                     rd_cnt_in      = '0;
                     acc_cnt_in     = '0;
                     state_in       = ST_WALK;
                  end else begin
                     rsp_valid_in = 1'b1;
                     cur_valid_in = 1'b0;
                     cur_ma_in    = '0;
                     fault_o_in   = 1'b0;
                     reinit_o_in  = fail_ff >= fault_limit_ff;
                  end
               end
            end
         end
         ST_WALK: begin
            if (rd_cnt_ff < CNT_W'(WINDOW_SIZE)) begin
               rd_en     = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (acc_cnt_ff == '0) begin
                  sum_in = SUM_W'(rd_data_ff);
                  lo_in  = rd_data_ff;
                  hi_in  = rd_data_ff;
               end else begin
                  sum_in = sum_ff + SUM_W'(rd_data_ff);
                  if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
                  if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
               end
               acc_cnt_in = acc_cnt_ff + 1'b1;
               if (acc_cnt_ff == CNT_W'(WINDOW_SIZE - 1)) begin
                  state_in = ST_TRIM;
               end
            end
         end
         ST_TRIM: begin
            trim_in  = sum_ff - SUM_W'(lo_ff) - SUM_W'(hi_ff);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            absd_in  = d_pos[DIFF_W-1] ? d_neg[DIFF_W-2:0] : d_pos[DIFF_W-2:0];
            neg_in   = d_pos[DIFF_W-1] ^ invert_sign_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mag_in   = MAG_W'(absd_ff) * MAG_W'(gain_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (mag_ff < idle_lim_ff) begin
               quo_in   = '0;
               state_in = ST_FIN;
            end else if (y_val >= Y_W'(SAT_LIM)) begin
               quo_in   = CURRENT_MAX;
               state_in = ST_FIN;
            end else begin
               y_in     = y_val[YQ_W-1:0];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // floor(y / D) by reciprocal multiply
            quo_in   = recip_prod[RECIP_K +: QUO_W];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               cur_valid_in = 1'b1;
               cur_ma_in    = neg_ff ? -quo_ext : quo_ext;
               fault_o_in   = fault_ff;
               reinit_o_in  = pend_reinit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         full_ff      <= 1'b0;
         fail_ff      <= '0;
         fault_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         full_ff      <= full_in;
         fail_ff      <= fail_in;
         fault_ff     <= fault_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_reinit_ff <= pend_reinit_in;
      rd_cnt_ff      <= rd_cnt_in;
      acc_cnt_ff     <= acc_cnt_in;
      sum_ff         <= sum_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      trim_ff        <= trim_in;
      absd_ff        <= absd_in;
      neg_ff         <= neg_in;
      mag_ff         <= mag_in;
      y_ff           <= y_in;
      quo_ff         <= quo_in;
      cur_valid_ff   <= cur_valid_in;
      cur_ma_ff      <= cur_ma_in;
      fault_o_ff     <= fault_o_in;
      reinit_o_ff    <= reinit_o_in;
   end

endmodule
